@@ hw/rtl/rv64_subset_decode_execute_core_defines.svh @@
// Assertion macros used by the checker file.
// Every property is sampled on clk_i and is off while rst_ni is low.
`ifndef RV64_SUBSET_DECODE_EXECUTE_CORE_DEFINES_SVH
`define RV64_SUBSET_DECODE_EXECUTE_CORE_DEFINES_SVH

// Check an expression on every clock edge.
`define RVDE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RVDE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rvde_pkg.sv @@
package rvde_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned ILEN = 32;

  // Major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  // funct3 codes for ALU operations
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  // funct3 code for doubleword load and store
  localparam logic [2:0] F3_DWORD = 3'd3;

  // funct3 codes for branches
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [XLEN-1:0] PC_STEP = XLEN'(4);

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_XOR = 3'd2,
    ALU_OR  = 3'd3,
    ALU_AND = 3'd4
  } alu_op_e;

  typedef enum logic [1:0] {
    WB_NONE = 2'd0,
    WB_ALU  = 2'd1,
    WB_MEM  = 2'd2
  } wb_src_e;

  // Decoded controls handed from decode to execute
  typedef struct packed {
    alu_op_e         alu_op;
    logic            use_imm;
    logic            use_pc;
    logic            is_branch;
    logic [2:0]      br_f3;
    logic            mem_read;
    logic            mem_write;
    logic            reg_write;
    wb_src_e         wb_src;
    logic            bad;
    logic [XLEN-1:0] imm;
  } dec_ctrl_t;

endpackage

@@ hw/rtl/rvde_decode.sv @@
module rvde_decode
  import rvde_pkg::*;
(
  input  logic [ILEN-1:0] instr_i,
  output dec_ctrl_t       ctrl_o
);

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [4:0]      rd;
  logic [XLEN-1:0] imm_i;
  logic [XLEN-1:0] imm_s;
  logic [XLEN-1:0] imm_b;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign f7  = instr_i[31:25];
  assign rd  = instr_i[11:7];

  // Sign-extended immediates
  assign imm_i = {{(XLEN-12){instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{(XLEN-12){instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{(XLEN-13){instr_i[31]}}, instr_i[31], instr_i[7],
                  instr_i[30:25], instr_i[11:8], 1'b0};

  // Decode opcode, funct3 and funct7 into controls
  always_comb begin
    ctrl_o        = '0;
    ctrl_o.alu_op = ALU_ADD;
    ctrl_o.wb_src = WB_NONE;
    ctrl_o.br_f3  = f3;
    case (opc)
      OPC_OP: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          ctrl_o.alu_op = ALU_ADD;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          ctrl_o.alu_op = ALU_SUB;
        end else if (f3 == F3_XOR && f7 == F7_BASE) begin
          ctrl_o.alu_op = ALU_XOR;
        end else if (f3 == F3_OR && f7 == F7_BASE) begin
          ctrl_o.alu_op = ALU_OR;
        end else if (f3 == F3_AND && f7 == F7_BASE) begin
          ctrl_o.alu_op = ALU_AND;
        end else begin
          ctrl_o.bad = 1'b1;
        end
        ctrl_o.reg_write = !ctrl_o.bad;
        ctrl_o.wb_src    = WB_ALU;
      end
      OPC_OP_IMM: begin
        ctrl_o.use_imm = 1'b1;
        ctrl_o.imm     = imm_i;
        case (f3)
          F3_ADD:  ctrl_o.alu_op = ALU_ADD;
          F3_XOR:  ctrl_o.alu_op = ALU_XOR;
          F3_OR:   ctrl_o.alu_op = ALU_OR;
          F3_AND:  ctrl_o.alu_op = ALU_AND;
          default: ctrl_o.bad    = 1'b1;
        endcase
        ctrl_o.reg_write = !ctrl_o.bad;
        ctrl_o.wb_src    = WB_ALU;
      end
      OPC_LOAD: begin
        if (f3 != F3_DWORD) begin
          ctrl_o.bad = 1'b1;
        end else begin
          ctrl_o.use_imm   = 1'b1;
          ctrl_o.imm       = imm_i;
          ctrl_o.mem_read  = 1'b1;
          ctrl_o.reg_write = 1'b1;
          ctrl_o.wb_src    = WB_MEM;
        end
      end
      OPC_STORE: begin
        if (f3 != F3_DWORD) begin
          ctrl_o.bad = 1'b1;
        end else begin
          ctrl_o.use_imm   = 1'b1;
          ctrl_o.imm       = imm_s;
          ctrl_o.mem_write = 1'b1;
        end
      end
      OPC_BRANCH: begin
        ctrl_o.use_imm   = 1'b1;
        ctrl_o.use_pc    = 1'b1;
        ctrl_o.imm       = imm_b;
        ctrl_o.is_branch = 1'b1;
        ctrl_o.bad       = !(f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU});
      end
      default: begin
        ctrl_o.bad = 1'b1;
      end
    endcase

    // Drop writes to x0 and clear the source when nothing is written
    if (rd == 5'd0) begin
      ctrl_o.reg_write = 1'b0;
    end
    if (!ctrl_o.reg_write) begin
      ctrl_o.wb_src = WB_NONE;
    end
  end

endmodule

@@ hw/rtl/rvde_execute.sv @@
module rvde_execute
  import rvde_pkg::*;
(
  input  dec_ctrl_t       ctrl_i,
  input  logic [XLEN-1:0] pc_i,
  input  logic [XLEN-1:0] src1_i,
  input  logic [XLEN-1:0] src2_i,
  output logic [XLEN-1:0] alu_value_o,
  output logic [XLEN-1:0] next_pc_o,
  output logic            branch_taken_o
);

  logic [XLEN-1:0] op_a;
  logic [XLEN-1:0] op_b;
  logic [XLEN-1:0] alu_res;
  logic            cond;

  // Select operands: pc for branch targets, immediate where the format has one
  assign op_a = ctrl_i.use_pc  ? pc_i       : src1_i;
  assign op_b = ctrl_i.use_imm ? ctrl_i.imm : src2_i;

  // Run the ALU
  always_comb begin
    case (ctrl_i.alu_op)
      ALU_ADD: alu_res = op_a + op_b;
      ALU_SUB: alu_res = op_a - op_b;
      ALU_XOR: alu_res = op_a ^ op_b;
      ALU_OR:  alu_res = op_a | op_b;
      ALU_AND: alu_res = op_a & op_b;
      default: alu_res = '0;
    endcase
  end

  // Evaluate the branch condition on the two sources
  always_comb begin
    case (ctrl_i.br_f3)
      F3_BEQ:  cond = (src1_i == src2_i);
      F3_BNE:  cond = (src1_i != src2_i);
      F3_BLT:  cond = ($signed(src1_i) <  $signed(src2_i));
      F3_BGE:  cond = ($signed(src1_i) >= $signed(src2_i));
      F3_BLTU: cond = (src1_i <  src2_i);
      F3_BGEU: cond = (src1_i >= src2_i);
      default: cond = 1'b0;
    endcase
  end

  // Zero the ALU value and the branch decision for an unsupported item
  assign alu_value_o    = ctrl_i.bad ? '0 : alu_res;
  assign branch_taken_o = ctrl_i.is_branch && !ctrl_i.bad && cond;
  assign next_pc_o      = branch_taken_o ? alu_value_o : (pc_i + PC_STEP);

endmodule

@@ hw/rtl/rv64_subset_decode_execute_core.sv @@
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+----------------------------
// command  | instruction_i pc_value_i src1_value_i src2_value_i | start & !busy at clk_i edge
// result   | dest_index_o .. unsupported_o                      | done_o high for one cycle
//
// Each item passes from accept to result through the input register, then
// through decode and the ALU into the result register.
// A new item can be accepted every cycle; busy never rises.
// rst_ni clears the valid bits asynchronously; payload registers are not reset.
// The receiver cannot stall, so the pipeline advances on every clock.
module rv64_subset_decode_execute_core
  import rvde_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [ILEN-1:0] instruction_i,
  input  logic [XLEN-1:0] pc_value_i,
  input  logic [XLEN-1:0] src1_value_i,
  input  logic [XLEN-1:0] src2_value_i,
  output logic            done_o,
  output logic [4:0]      dest_index_o,
  output logic            reg_write_o,
  output logic [1:0]      writeback_source_o,
  output logic            mem_read_o,
  output logic            mem_write_o,
  output logic [XLEN-1:0] alu_value_o,
  output logic [XLEN-1:0] store_data_o,
  output logic [XLEN-1:0] next_pc_o,
  output logic            branch_taken_o,
  output logic            unsupported_o
);

  logic            accept;
  logic            valid_q;
  logic            done_q;
  logic [ILEN-1:0] instr_q;
  logic [XLEN-1:0] pc_q;
  logic [XLEN-1:0] src1_q;
  logic [XLEN-1:0] src2_q;

  dec_ctrl_t       ctrl;
  logic [XLEN-1:0] alu_d;
  logic [XLEN-1:0] next_pc_d;
  logic            taken_d;

  logic [4:0]      dest_q;
  logic            reg_write_q;
  wb_src_e         wb_src_q;
  logic            mem_read_q;
  logic            mem_write_q;
  logic [XLEN-1:0] alu_q;
  logic [XLEN-1:0] store_q;
  logic [XLEN-1:0] next_pc_q;
  logic            taken_q;
  logic            bad_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= accept;
      done_q  <= valid_q;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instruction_i;
      pc_q    <= pc_value_i;
      src1_q  <= src1_value_i;
      src2_q  <= src2_value_i;
    end
  end

  rvde_decode u_decode (
    .instr_i (instr_q),
    .ctrl_o  (ctrl)
  );

  rvde_execute u_execute (
    .ctrl_i         (ctrl),
    .pc_i           (pc_q),
    .src1_i         (src1_q),
    .src2_i         (src2_q),
    .alu_value_o    (alu_d),
    .next_pc_o      (next_pc_d),
    .branch_taken_o (taken_d)
  );

  // Capture the result; it holds until the next item arrives
  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      dest_q      <= instr_q[11:7];
      reg_write_q <= ctrl.reg_write;
      wb_src_q    <= ctrl.wb_src;
      mem_read_q  <= ctrl.mem_read;
      mem_write_q <= ctrl.mem_write;
      alu_q       <= alu_d;
      store_q     <= src2_q;
      next_pc_q   <= next_pc_d;
      taken_q     <= taken_d;
      bad_q       <= ctrl.bad;
    end
  end

  assign done_o             = done_q;
  assign dest_index_o       = dest_q;
  assign reg_write_o        = reg_write_q;
  assign writeback_source_o = wb_src_q;
  assign mem_read_o         = mem_read_q;
  assign mem_write_o        = mem_write_q;
  assign alu_value_o        = alu_q;
  assign store_data_o       = store_q;
  assign next_pc_o          = next_pc_q;
  assign branch_taken_o     = taken_q;
  assign unsupported_o      = bad_q;

endmodule

@@ hw/rtl/rvde_checker.sv @@
`include "rv64_subset_decode_execute_core_defines.svh"

module rvde_checker
  import rvde_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic [XLEN-1:0] pc_value_i,
  input logic            done_o,
  input logic [4:0]      dest_index_o,
  input logic            reg_write_o,
  input logic [1:0]      writeback_source_o,
  input logic            mem_read_o,
  input logic            mem_write_o,
  input logic [XLEN-1:0] alu_value_o,
  input logic [XLEN-1:0] next_pc_o,
  input logic            branch_taken_o,
  input logic            unsupported_o
);

  // A result only appears after an accepted item has passed the input and result registers
  `RVDE_ASSERT_IMPL(a_done_follows_start, done_o, $past(start && !busy, 2), "result without item")

  // Writes to x0 never leave the block
  `RVDE_ASSERT_IMPL(a_no_x0_write, done_o && reg_write_o, dest_index_o != 5'd0, "write to x0")

  // No write-back source without a register write
  `RVDE_ASSERT_IMPL(a_wb_src_idle, done_o && !reg_write_o,
                    writeback_source_o == WB_NONE, "source set without write")

  // An unsupported item acts as a no-op
  `RVDE_ASSERT_IMPL(a_bad_is_nop, done_o && unsupported_o,
                    !mem_read_o && !mem_write_o && !branch_taken_o && !reg_write_o &&
                    alu_value_o == '0 && next_pc_o == $past(pc_value_i, 2) + PC_STEP,
                    "unsupported item had effects")

endmodule

bind rv64_subset_decode_execute_core rvde_checker u_rvde_checker (.*);
